### hdl/spf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

  // Most number bytes (semi-octet pairs) a frame may carry.
  localparam int unsigned MaxNumberBytes = 10;

  // Most result bytes one request can cause (empty number: header + tail).
  localparam int unsigned MaxBurst = 6;
  localparam int unsigned BurstW   = $clog2(MaxBurst + 1);

  // Depth of the command queue between front and back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_DIGIT = 2'd1,
    FUNC_DATA  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_NO_SPACE = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] symbol;
    logic [4:0] number_length;
    logic [7:0] data_length;
    logic [7:0] address_type;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       last;
  } out_t;

  // One queued burst: bytes in order, count, shared status, last on final byte.
  typedef struct packed {
    logic [MaxBurst-1:0][7:0] bytes;
    logic [BurstW-1:0]        cnt;
    status_e                  status;
    logic                     last;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/spf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module spf_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_wdata_i,
  input  wire logic          accept_i,
  input  wire spf_pkg::in_t  req_i,
  output spf_pkg::cmd_t      cmd_o,
  output logic               push_o
);

  function automatic logic [3:0] to_semi(input logic [7:0] c);
    logic [3:0] r;
    r = 4'hF;
    if (c >= 8'h30 && c <= 8'h39) r = c[3:0];
    else if (c == 8'h2A)          r = 4'hA;
    else if (c == 8'h23)          r = 4'hB;
    else if (c >= 8'h61 && c <= 8'h63) r = 4'(c - 8'h61) + 4'hC;
    return r;
  endfunction

  logic [7:0] max_q, max_d;
  logic [7:0] type_q, type_d;
  logic [4:0] dt_q, dt_d;
  logic [7:0] pt_q, pt_d;
  logic [4:0] dc_q, dc_d;
  logic [7:0] pc_q, pc_d;
  logic [3:0] nib_q, nib_d;
  logic       fits_q, fits_d;
  logic       disc_q, disc_d;

  logic [4:0] digs;
  logic [8:0] need;
  logic [4:0] pos;
  logic [3:0] nib;
  logic       tail;
  logic [spf_pkg::BurstW-1:0] n;
  spf_pkg::cmd_t cmd;

  assign digs = 5'((6'({1'b0, req_i.number_length}) + 6'd1) >> 1);
  assign pos  = (req_i.number_length != 5'd0) ? (digs + 5'd6) : 5'd5;
  assign need = 9'(pos) + 9'd1 + 9'(req_i.data_length);
  assign nib  = to_semi(req_i.symbol);

  always_comb begin
    max_d  = cfg_we_i ? cfg_wdata_i : max_q;
    type_d = type_q;
    dt_d   = dt_q;
    pt_d   = pt_q;
    dc_d   = dc_q;
    pc_d   = pc_q;
    nib_d  = nib_q;
    fits_d = fits_q;
    disc_d = disc_q;
    cmd    = '0;
    cmd.status = spf_pkg::ST_OK;
    n      = '0;
    tail   = 1'b0;

    if (accept_i) begin
      unique case (req_i.func)
        spf_pkg::FUNC_START: begin
          disc_d = 1'b1;
          if (digs > 5'(spf_pkg::MaxNumberBytes)) begin
            cmd.status = spf_pkg::ST_TOO_LONG;
            cmd.last   = 1'b1;
            n          = spf_pkg::BurstW'(1);
          end else if ({1'b0, max_q} < 9'(digs) + 9'd4) begin
            cmd.status = spf_pkg::ST_NO_SPACE;
            cmd.last   = 1'b1;
            n          = spf_pkg::BurstW'(1);
          end else begin
            type_d = req_i.address_type;
            dt_d   = req_i.number_length;
            pt_d   = req_i.data_length;
            dc_d   = '0;
            pc_d   = '0;
            nib_d  = '0;
            disc_d = 1'b0;
            fits_d = ({1'b0, max_q} >= need);
            cmd.bytes[0] = 8'h01;
            cmd.bytes[1] = 8'h00;
            cmd.bytes[2] = {3'b000, req_i.number_length};
            if (req_i.number_length != 5'd0) begin
              cmd.bytes[3] = req_i.address_type;
              n = spf_pkg::BurstW'(4);
            end else begin
              n    = spf_pkg::BurstW'(3);
              tail = 1'b1;
            end
          end
        end
        spf_pkg::FUNC_DIGIT: begin
          if (!disc_q && dc_q < dt_q) begin
            dc_d = dc_q + 5'd1;
            if (!dc_q[0]) begin
              nib_d = nib;
              if (dc_d == dt_q) begin
                cmd.bytes[0] = {4'hF, nib};
                n = spf_pkg::BurstW'(1);
              end
            end else begin
              cmd.bytes[0] = {nib, nib_q};
              n = spf_pkg::BurstW'(1);
            end
            tail = (dc_d == dt_q);
          end
        end
        spf_pkg::FUNC_DATA: begin
          if (!disc_q && dc_q == dt_q && fits_q && pc_q < pt_q) begin
            pc_d = pc_q + 8'd1;
            cmd.bytes[0] = req_i.symbol;
            cmd.last     = (pc_d == pt_q);
            n = spf_pkg::BurstW'(1);
            if (pc_d == pt_q) disc_d = 1'b1;
          end
        end
        default: ;
      endcase

      // PID, DCS and UDL when the data fits
      if (tail) begin
        cmd.bytes[n] = 8'h00;
        n = n + spf_pkg::BurstW'(1);
        cmd.bytes[n] = 8'h00;
        n = n + spf_pkg::BurstW'(1);
        if (fits_d) begin
          cmd.bytes[n] = pt_d;
          n = n + spf_pkg::BurstW'(1);
          cmd.last = (pt_d == 8'd0);
          if (pt_d == 8'd0) disc_d = 1'b1;
        end else begin
          cmd.last = 1'b1;
          disc_d   = 1'b1;
        end
      end
    end
    cmd.cnt = n;
  end

  assign cmd_o  = cmd;
  assign push_o = accept_i && (n != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= 8'hFF;
      type_q <= '0;
      dt_q   <= '0;
      pt_q   <= '0;
      dc_q   <= '0;
      pc_q   <= '0;
      nib_q  <= '0;
      fits_q <= 1'b0;
      disc_q <= 1'b1;
    end else begin
      max_q  <= max_d;
      type_q <= type_d;
      dt_q   <= dt_d;
      pt_q   <= pt_d;
      dc_q   <= dc_d;
      pc_q   <= pc_d;
      nib_q  <= nib_d;
      fits_q <= fits_d;
      disc_q <= disc_d;
    end
  end

endmodule

`default_nettype wire

### hdl/spf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module spf_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire spf_pkg::cmd_t  push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output spf_pkg::cmd_t       head_o,
  output logic                empty_o
);

  localparam int unsigned CntW = spf_pkg::QueuePtrW + 1;

  spf_pkg::cmd_t mem_q [spf_pkg::QueueDepth];

  logic [spf_pkg::QueuePtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(spf_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + spf_pkg::QueuePtrW'(1) : wr_q;
    rd_d  = do_pop  ? rd_q + spf_pkg::QueuePtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### hdl/spf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module spf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire spf_pkg::cmd_t  head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output spf_pkg::out_t       out_rsp_o
);

  logic [spf_pkg::BurstW-1:0] idx_q, idx_d;
  logic                       vld_q, vld_d;
  spf_pkg::out_t              out_q, out_d;
  logic                       load, final_byte;

  assign load       = !empty_i && (!vld_q || out_ready_i);
  assign final_byte = (idx_q == head_i.cnt - spf_pkg::BurstW'(1));
  assign pop_o      = load && final_byte;

  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    out_d = out_q;
    if (load) begin
      out_d.out_byte = head_i.bytes[idx_q];
      out_d.status   = head_i.status;
      out_d.last     = head_i.last && final_byte;
      vld_d          = 1'b1;
      idx_d          = final_byte ? '0 : idx_q + spf_pkg::BurstW'(1);
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

### hdl/sms_submit_pdu_framer.sv
// Channel   Handshake                  Payload
// ------    -------------------------  -----------------------------------
// in        in_valid_i / in_ready_o    in_req_i  (func, symbol, lengths, type)
// out       out_valid_o / out_ready_i  out_rsp_o (out_byte, status, last)
// cfg       cfg_we_i                   cfg_wdata_i (max_length)
//
// One request is taken per cycle while the command queue has room; the front
// decides all state in that cycle and queues the burst of bytes it causes.
// The back drains one byte per cycle while the receiver is ready; a start request
// causes up to six bytes, a digit or data request zero to four.
// Reset is asynchronous: max_length goes to 255 and the framer is idle.
// Output stalls only fill the queue; in_ready_o drops when it is full.
`timescale 1ns / 1ps
`default_nettype none

module sms_submit_pdu_framer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_wdata_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire spf_pkg::in_t  in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output spf_pkg::out_t      out_rsp_o
);

  spf_pkg::cmd_t cmd, head;
  logic          push, full, empty, pop, accept;

  // Requests are taken whenever the queue can hold one more burst.
  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  // Front: config register, message state, byte burst per request.
  spf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .req_i       (in_req_i),
    .cmd_o       (cmd),
    .push_o      (push)
  );

  // Short queue lets the front keep going while the output is stalled.
  spf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  // Back: serializes each burst into the registered output stage.
  spf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

### test/sms_submit_pdu_framer_tb.sv
`timescale 1ns / 1ps

module sms_submit_pdu_framer_tb;
  import spf_pkg::*;

  // func code outside the enum; the framer must ignore it
  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int unsigned MaxShown = 10;
  // random requests; the directed part adds 26 more
  localparam int unsigned RandomItems = 84;

  // Predicts the frame bytes and checks them in order.
  class frame_scoreboard;
    int unsigned frame_cap;
    logic [7:0]  toa;
    logic [4:0]  num_digits;
    logic [4:0]  digits_seen;
    logic [7:0]  ud_len;
    logic [7:0]  ud_seen;
    logic [3:0]  half_digit;
    bit          ud_fits;
    bit          idle;
    out_t        frame_q[$];
    int unsigned errors;

    function new();
      frame_cap   = 255;
      toa         = '0;
      num_digits  = '0;
      digits_seen = '0;
      ud_len      = '0;
      ud_seen     = '0;
      half_digit  = '0;
      ud_fits     = 1'b0;
      idle        = 1'b1;
      errors      = 0;
    endfunction

    function void set_limit(logic [7:0] v);
      frame_cap = 32'(v);
    endfunction

    function int unsigned outstanding();
      return frame_q.size();
    endfunction

    function void expect_byte(logic [7:0] b, status_e s, bit l);
      out_t e;
      e.out_byte = b;
      e.status   = s;
      e.last     = l;
      frame_q.push_back(e);
    endfunction

    function logic [3:0] semi_octet(logic [7:0] c);
      logic [7:0] d;
      d = 8'h0F;
      if (c >= "0" && c <= "9") d = c - "0";
      else if (c == "*") d = 8'h0A;
      else if (c == "#") d = 8'h0B;
      else if (c >= "a" && c <= "c") d = c - "a" + 8'h0C;
      return d[3:0];
    endfunction

    // PID and DCS, then UDL when the user data fits.
    function void close_header();
      expect_byte(8'h00, ST_OK, 1'b0);
      if (ud_fits) begin
        expect_byte(8'h00, ST_OK, 1'b0);
        expect_byte(ud_len, ST_OK, ud_len == 8'd0);
        if (ud_len == 8'd0) idle = 1'b1;
      end else begin
        expect_byte(8'h00, ST_OK, 1'b1);
        idle = 1'b1;
      end
    endfunction

    function void note_request(in_t r);
      int unsigned digs;
      int unsigned pos;
      logic [3:0]  nib;
      digs = (32'(r.number_length) + 1) / 2;
      case (r.func)
        FUNC_START: begin
          idle = 1'b1;
          if (digs > MaxNumberBytes) begin
            expect_byte(8'h00, ST_TOO_LONG, 1'b1);
          end else if (frame_cap < digs + 4) begin
            expect_byte(8'h00, ST_NO_SPACE, 1'b1);
          end else begin
            toa         = r.address_type;
            num_digits  = r.number_length;
            ud_len      = r.data_length;
            digits_seen = '0;
            ud_seen     = '0;
            half_digit  = '0;
            idle        = 1'b0;
            pos         = (r.number_length != 5'd0) ? digs + 6 : 5;
            ud_fits     = (frame_cap >= pos + 1 + 32'(r.data_length));
            expect_byte(8'h01, ST_OK, 1'b0);
            expect_byte(8'h00, ST_OK, 1'b0);
            expect_byte({3'b000, r.number_length}, ST_OK, 1'b0);
            if (r.number_length != 5'd0) expect_byte(toa, ST_OK, 1'b0);
            else close_header();
          end
        end
        FUNC_DIGIT: begin
          if (!idle && digits_seen < num_digits) begin
            nib = semi_octet(r.symbol);
            if (!digits_seen[0]) begin
              half_digit  = nib;
              digits_seen = digits_seen + 5'd1;
              if (digits_seen == num_digits) expect_byte({4'hF, half_digit}, ST_OK, 1'b0);
            end else begin
              expect_byte({nib, half_digit}, ST_OK, 1'b0);
              digits_seen = digits_seen + 5'd1;
            end
            if (digits_seen == num_digits) close_header();
          end
        end
        FUNC_DATA: begin
          if (!idle && digits_seen == num_digits && ud_fits && ud_seen < ud_len) begin
            ud_seen = ud_seen + 8'd1;
            expect_byte(r.symbol, ST_OK, ud_seen == ud_len);
            if (ud_seen == ud_len) idle = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_response(out_t got);
      out_t want;
      if (frame_q.size() == 0) begin
        errors++;
        if (errors <= MaxShown)
          $display("unexpected byte %02h status %0d last %0b", got.out_byte, got.status,
                   got.last);
        return;
      end
      want = frame_q.pop_front();
      if (got.out_byte !== want.out_byte || got.status !== want.status ||
          got.last !== want.last) begin
        errors++;
        if (errors <= MaxShown)
          $display("mismatch: got %02h/%0d/%0b, expected %02h/%0d/%0b", got.out_byte,
                   got.status, got.last, want.out_byte, want.status, want.last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_req_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_rsp_o;

  frame_scoreboard sb = new();
  logic [7:0]  stim_cap = 8'd255;   // mirror of max_length for shaping stimulus
  string       dial_set = "0123456789*#abc";

  sms_submit_pdu_framer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Both handshakes are sampled in one process at the edge, so a request
  // is always noted before any byte it causes can be checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_req_i);
      if (out_valid_o && out_ready_i) sb.check_response(out_rsp_o);
    end
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Number character: mostly from the dial set, sometimes any byte.
  function automatic logic [7:0] dial_char();
    if ($urandom_range(0, 9) < 8) return dial_set[$urandom_range(0, 14)];
    return 8'($urandom);
  endfunction

  // Receiver: ready runs (mostly short, some long) broken by stalls.
  initial begin
    int unsigned run;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      out_ready_i <= 1'b0;
      repeat (1 + idle_cycles()) @(posedge clk_i);
    end
  end

  // Called back to back with no time in between, so valid is only dropped
  // when a gap follows; it is never lowered and raised in one step.
  task automatic send_request(input in_t r);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_start(input logic [4:0] nlen, input logic [7:0] dlen,
                            input logic [7:0] toa);
    in_t r;
    r.func          = FUNC_START;
    r.symbol        = 8'($urandom);
    r.number_length = nlen;
    r.data_length   = dlen;
    r.address_type  = toa;
    send_request(r);
  endtask

  // Digit, data or unused request; the length fields carry noise.
  task automatic send_item(input logic [1:0] func, input logic [7:0] symbol);
    in_t r;
    r.func          = func;
    r.symbol        = symbol;
    r.number_length = 5'($urandom);
    r.data_length   = 8'($urandom);
    r.address_type  = 8'($urandom);
    send_request(r);
  endtask

  // max_length is only written with the framer drained and quiet.
  // First wait for the clock so the last accepted request has been noted.
  task automatic program_cap(input logic [7:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_limit(v);
    cfg_we_i    <= 1'b0;
    stim_cap     = v;
  endtask

  // One message, mostly well formed; some are cut short (the next start
  // aborts them), get a stray data request among the digits, or trailing
  // noise. n counts the requests sent.
  task automatic random_message(output int unsigned n);
    int unsigned kind, nlen, dlen, digs, pos, total, cut;
    bit          taken, fits;
    n = 0;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // number too long
      send_start(5'($urandom_range(21, 31)), 8'($urandom), 8'($urandom));
      n = 1;
      if ($urandom_range(0, 1) == 1) begin
        send_item(FUNC_DIGIT, dial_char());
        n++;
      end
      return;
    end
    nlen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
    kind = $urandom_range(0, 99);
    if (kind < 65) dlen = $urandom_range(0, 6);
    else if (kind < 95) dlen = $urandom_range(7, 30);
    else dlen = $urandom_range(31, 255);
    digs  = (nlen + 1) / 2;
    taken = 32'(stim_cap) >= digs + 4;
    pos   = (nlen != 0) ? digs + 6 : 5;
    fits  = 32'(stim_cap) >= pos + 1 + dlen;
    total = nlen + ((taken && fits) ? dlen : $urandom_range(0, 2));
    cut   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total) : total;
    send_start(5'(nlen), 8'(dlen), 8'($urandom));
    n = 1;
    for (int unsigned i = 0; i < cut; i++) begin
      if (i < nlen) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(FUNC_DATA, 8'($urandom));
          n++;
        end
        send_item(FUNC_DIGIT, dial_char());
      end else begin
        send_item(FUNC_DATA, 8'($urandom));
      end
      n++;
    end
    if ($urandom_range(0, 9) == 0) begin
      send_item(($urandom_range(0, 1) == 1) ? FUNC_DIGIT : FuncUnused, 8'($urandom));
      n++;
    end
  endtask

  initial begin
    logic [7:0]  caps [10];
    int unsigned done_items;
    int unsigned n;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, max_length at its reset value.
    send_start(5'd0, 8'd0, 8'hFF);            // empty number, no data: six bytes
    send_start(5'd1, 8'd2, 8'h91);            // odd digit count, 0xF fill
    send_item(FUNC_DIGIT, "#");
    send_item(FUNC_DATA, 8'h00);
    send_item(FUNC_DATA, 8'hFF);
    send_item(FUNC_DATA, 8'h55);              // frame ended: ignored
    send_start(5'd8, 8'd0, 8'h81);            // digits, *, a to c and unmapped bytes
    send_item(FUNC_DIGIT, "0");
    send_item(FUNC_DIGIT, "9");
    send_item(FUNC_DATA, 8'h11);              // data before number complete
    send_item(FUNC_DIGIT, "*");
    send_item(FUNC_DIGIT, "b");
    send_item(FUNC_DIGIT, "a");
    send_item(FUNC_DIGIT, "c");
    send_item(FUNC_DIGIT, "Z");
    send_item(FUNC_DIGIT, 8'hFF);
    send_item(FuncUnused, 8'hA5);
    send_item(FUNC_DIGIT, "1");               // idle: ignored
    send_start(5'd31, 8'd255, 8'h00);         // too long
    send_start(5'd21, 8'd0, 8'hFF);           // too long, just over
    send_start(5'd20, 8'd255, 8'hAA);         // widest number, data cannot fit
    send_item(FUNC_DIGIT, "3");
    send_item(FUNC_DIGIT, "4");
    send_item(FUNC_DIGIT, "5");
    send_start(5'd0, 8'd250, 8'h00);          // aborts the open message
    send_item(FUNC_DATA, 8'h77);              // data does not fit: ignored

    // Random part across several max_length settings, extremes included.
    caps = '{8'd0, 8'd3, 8'd4, 8'd5, 8'd9, 8'd14, 8'd15, 8'd40, 8'd255, 8'd0};
    caps[9] = 8'($urandom_range(0, 255));
    done_items = 0;
    for (int p = 0; p < 10; p++) begin
      program_cap(caps[p]);
      while (done_items < (RandomItems * (p + 1)) / 10) begin
        random_message(n);
        done_items += n;
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### sms_submit_pdu_framer.f
hdl/spf_pkg.sv
hdl/spf_front.sv
hdl/spf_queue.sv
hdl/spf_back.sv
hdl/sms_submit_pdu_framer.sv
test/sms_submit_pdu_framer_tb.sv
